// ----- rtl/core/erd_pkg.sv -----
// Shared types and constants for the escaped row deframer.
package erd_pkg;

   // Input item kinds carried on the request tuser.
   localparam logic OP_BYTE = 1'b0;
   localparam logic OP_EOF  = 1'b1;

   // Result kinds carried on the result tuser.
   localparam logic [1:0] KIND_DATA      = 2'd0;
   localparam logic [1:0] KIND_FIELD_END = 2'd1;
   localparam logic [1:0] KIND_ROW_END   = 2'd2;
   localparam logic [1:0] KIND_ERROR     = 2'd3;

   // Error codes.
   localparam logic [1:0] ERR_NONE       = 2'd0;
   localparam logic [1:0] ERR_BAD_ESCAPE = 2'd1;
   localparam logic [1:0] ERR_OPEN_ESC   = 2'd2;
   localparam logic [1:0] ERR_COLUMNS    = 2'd3;

   // Special characters.
   localparam logic [7:0] CHAR_LF        = 8'h0A;
   localparam logic [7:0] CHAR_CR        = 8'h0D;
   localparam logic [7:0] CHAR_PIPE      = 8'h7C;
   localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
   localparam logic [7:0] CHAR_N         = 8'h6E;

   // Register map.
   localparam logic REG_EXPECTED_COLUMNS = 1'b0;
   localparam logic [7:0] EXPECTED_COLUMNS_RESET = 8'd1;

   // Result queue depth and the fill level at which two more fit.
   localparam int unsigned RSP_DEPTH = 4;
   localparam logic [2:0] RSP_ROOM_LIMIT = 3'd2;
   localparam logic [31:0] LINE_MAX = 32'hFFFF_FFFF;

   // Parser state carried between items.
   typedef struct packed {
      logic        esc_waiting;
      logic        cr_held;
      logic        line_started;
      logic [7:0]  col_counter;
      logic [31:0] line_counter;
      logic        halted;
   } erd_state_type;

   // One result item.
   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  out_byte;
      logic [7:0]  column_index;
      logic [31:0] row_number;
      logic [1:0]  error_code;
      logic        last;
   } erd_result_type;

   // Builds a result with the last flag clear.
   function automatic erd_result_type make_result(
      input logic [1:0]  kind,
      input logic [7:0]  data,
      input logic [1:0]  err,
      input logic [7:0]  column,
      input logic [31:0] row
   );
      erd_result_type r;
      r.kind         = kind;
      r.out_byte     = data;
      r.column_index = column;
      r.row_number   = row;
      r.error_code   = err;
      r.last         = 1'b0;
      return r;
   endfunction

endpackage

// ----- rtl/core/escaped_row_deframer.sv -----
// Top level of the escaped row deframer: input register, parser state, result queue.
//
//   Channel   Direction  Handshake          Contents
//   req_*     in         tvalid/tready      tdata = in_byte, tuser = op
//   rsp_*     out        tvalid/tready      tdata = result fields, tuser = kind, tlast
//   csr_*     in         APB write/read     expected_columns at byte address 0
//
// One request per clock when results drain as fast as they are made; a request
// that makes two results (a held carriage return followed by a byte) queues both,
// and they leave one at a time. A request is held in the input register, parsed in
// a single pass, and its results leave from a four-entry queue.
// Reset clears the parser state, the queue and sets expected_columns to one.
// Result stalls back up into the input register only when the queue has fewer than two
// free entries.
module escaped_row_deframer import erd_pkg::*; #(
   parameter int unsigned MAX_COLUMNS = 255
) (
   input  logic        clock,
   input  logic        reset,
   // Request channel.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] in_byte
   input  logic        req_tuser,   // [0] op
   // Result channel.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,   // [7:0] out_byte, [15:8] column_index,
                                    // [47:16] row_number, [49:48] error_code, zero pad
   output logic [1:0]  rsp_tuser,   // [1:0] kind
   output logic        rsp_tlast,
   // Configuration port.
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   logic           in_valid_ff;
   logic           in_valid_in;
   logic           in_op_ff;
   logic [7:0]     in_byte_ff;
   logic [7:0]     expected_ff;
   logic [7:0]     expected_in;
   erd_state_type  state_ff;
   erd_state_type  state_in;
   erd_state_type  step_next;
   erd_result_type res0;
   erd_result_type res1;
   erd_result_type head;
   logic [1:0]     res_count;
   logic [1:0]     push_count;
   logic           has_room;
   logic           not_empty;
   logic           parse_go;
   logic           req_take;
   logic           csr_write;

   // The input register drains whenever the queue can take two results.
   assign parse_go   = in_valid_ff && has_room;
   assign req_tready = !in_valid_ff || parse_go;
   assign req_take   = req_tvalid && req_tready;
   assign push_count = parse_go ? res_count : 2'd0;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (parse_go) begin
         in_valid_in = 1'b0;
      end
      state_in = parse_go ? step_next : state_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         state_ff    <= '0;
      end else begin
         in_valid_ff <= in_valid_in;
         state_ff    <= state_in;
      end
   end

   // Request payload register.
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_op_ff   <= req_tuser;
         in_byte_ff <= req_tdata;
      end
   end

   // Configuration register.
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      expected_in = expected_ff;
      if (csr_write && (csr_paddr[2] == REG_EXPECTED_COLUMNS)) begin
         expected_in = csr_pwdata[7:0];
      end
      csr_prdata = (csr_paddr[2] == REG_EXPECTED_COLUMNS) ? {24'd0, expected_ff} : 32'd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         expected_ff <= EXPECTED_COLUMNS_RESET;
      end else begin
         expected_ff <= expected_in;
      end
   end

   erd_step #(
      .MAX_COLUMNS (MAX_COLUMNS)
   ) u_step (
      .state            (state_ff),
      .op               (in_op_ff),
      .in_byte          (in_byte_ff),
      .expected_columns (expected_ff),
      .state_next       (step_next),
      .res0             (res0),
      .res1             (res1),
      .res_count        (res_count)
   );

   erd_rsp_fifo u_rsp_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_count (push_count),
      .push0      (res0),
      .push1      (res1),
      .pop        (rsp_tready),
      .head       (head),
      .not_empty  (not_empty),
      .has_room   (has_room)
   );

   // Result channel outputs.
   assign rsp_tvalid = not_empty;
   assign rsp_tuser  = head.kind;
   assign rsp_tlast  = head.last;
   assign rsp_tdata  = {6'd0, head.error_code, head.row_number, head.column_index,
                        head.out_byte};

   // A halted parser produces no results.
   a_halted_silent: assert property (@(posedge clock) disable iff (reset)
      state_ff.halted |-> (push_count == 2'd0))
      else $error("results produced while halted");

   // Pushing an error result halts the parser.
   a_error_halts: assert property (@(posedge clock) disable iff (reset)
      ((push_count != 2'd0) && ((res0.kind == KIND_ERROR) || (res1.kind == KIND_ERROR)))
      |=> state_ff.halted)
      else $error("error result without halt");

   // Every result belongs to a counted line.
   a_row_nonzero: assert property (@(posedge clock) disable iff (reset)
      (push_count != 2'd0) |-> (res0.row_number != 32'd0))
      else $error("result with row number zero");

   // A full input register that cannot drain refuses new requests.
   a_hold_input: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !has_room) |-> !req_tready)
      else $error("request taken over a held one");

endmodule

// ----- rtl/core/erd_step.sv -----
// Combinational parse of one input item: next state and up to two results.
module erd_step import erd_pkg::*; #(
   parameter int unsigned MAX_COLUMNS = 255
) (
   input  erd_state_type  state,
   input  logic           op,
   input  logic [7:0]     in_byte,
   input  logic [7:0]     expected_columns,
   output erd_state_type  state_next,
   output erd_result_type res0,
   output erd_result_type res1,
   output logic [1:0]     res_count
);

   localparam logic [7:0] FIELD_CAP = 8'((MAX_COLUMNS < 255) ? MAX_COLUMNS : 255);

   // Error code produced when a row closes (none when the row is good).
   function automatic logic [1:0] row_end_code(
      input logic       esc,
      input logic [7:0] fc,
      input logic [7:0] expct
   );
      logic [1:0] code;
      code = ERR_NONE;
      if (esc) begin
         code = ERR_OPEN_ESC;
      end else if ((fc >= FIELD_CAP) || (({1'b0, fc} + 9'd1) != {1'b0, expct})) begin
         code = ERR_COLUMNS;
      end
      return code;
   endfunction

   always_comb begin
      logic [31:0]    lc_eff;
      logic [1:0]     rcode;
      logic           esc_a;
      logic           have_a;
      logic           have_b;
      logic           stop_a;
      erd_result_type res_a;
      erd_result_type res_b;

      state_next = state;
      res0       = '0;
      res1       = '0;
      res_count  = 2'd0;
      have_a     = 1'b0;
      have_b     = 1'b0;
      stop_a     = 1'b0;
      res_a      = '0;
      res_b      = '0;
      rcode      = ERR_NONE;
      esc_a      = state.esc_waiting;

      // A byte that opens a line advances the saturating line counter.
      lc_eff = state.line_counter;
      if ((op == OP_BYTE) && !state.line_started && (state.line_counter != LINE_MAX)) begin
         lc_eff = state.line_counter + 32'd1;
      end

      if (state.halted) begin
         state_next = state;
      end else if (op == OP_EOF) begin
         // End of file closes an open line, then rewinds for the next file.
         if (state.line_started) begin
            have_a = 1'b1;
            rcode  = row_end_code(state.esc_waiting, state.col_counter,
                                  expected_columns);
            if (rcode != ERR_NONE) begin
               res_a = make_result(KIND_ERROR, 8'd0, rcode, state.col_counter, lc_eff);
               state_next.halted = 1'b1;
            end else begin
               res_a = make_result(KIND_ROW_END, 8'd0, ERR_NONE, state.col_counter,
                                   lc_eff);
            end
         end
         state_next.esc_waiting   = 1'b0;
         state_next.cr_held       = 1'b0;
         state_next.line_started  = 1'b0;
         state_next.col_counter   = 8'd0;
         state_next.line_counter  = 32'd0;
      end else if (in_byte == CHAR_LF) begin
         // Newline closes the row; a held carriage return is dropped.
         have_a = 1'b1;
         rcode  = row_end_code(state.esc_waiting, state.col_counter, expected_columns);
         state_next.cr_held      = 1'b0;
         state_next.line_counter = lc_eff;
         if (rcode != ERR_NONE) begin
            res_a = make_result(KIND_ERROR, 8'd0, rcode, state.col_counter, lc_eff);
            state_next.halted       = 1'b1;
            state_next.line_started = 1'b1;
         end else begin
            res_a = make_result(KIND_ROW_END, 8'd0, ERR_NONE, state.col_counter, lc_eff);
            state_next.line_started = 1'b0;
            state_next.col_counter  = 8'd0;
         end
      end else begin
         state_next.line_started = 1'b1;
         state_next.line_counter = lc_eff;
         state_next.cr_held      = 1'b0;

         // A held CR not followed by newline is a plain byte, or an escape error.
         if (state.cr_held) begin
            have_a = 1'b1;
            esc_a  = 1'b0;
            if (state.esc_waiting) begin
               res_a  = make_result(KIND_ERROR, 8'd0, ERR_BAD_ESCAPE, state.col_counter,
                                    lc_eff);
               stop_a = 1'b1;
               state_next.halted = 1'b1;
            end else begin
               res_a = make_result(KIND_DATA, CHAR_CR, ERR_NONE, state.col_counter,
                                   lc_eff);
            end
         end
         state_next.esc_waiting = esc_a;

         // The current byte: hold a carriage return, else decode it.
         if (!stop_a) begin
            if (in_byte == CHAR_CR) begin
               state_next.cr_held = 1'b1;
            end else if (esc_a) begin
               have_b = 1'b1;
               state_next.esc_waiting = 1'b0;
               if ((in_byte == CHAR_BACKSLASH) || (in_byte == CHAR_PIPE)) begin
                  res_b = make_result(KIND_DATA, in_byte, ERR_NONE, state.col_counter,
                                      lc_eff);
               end else if (in_byte == CHAR_N) begin
                  res_b = make_result(KIND_DATA, CHAR_LF, ERR_NONE, state.col_counter,
                                      lc_eff);
               end else begin
                  res_b = make_result(KIND_ERROR, 8'd0, ERR_BAD_ESCAPE,
                                      state.col_counter, lc_eff);
                  state_next.halted = 1'b1;
               end
            end else if (in_byte == CHAR_BACKSLASH) begin
               state_next.esc_waiting = 1'b1;
            end else if (in_byte == CHAR_PIPE) begin
               have_b = 1'b1;
               res_b  = make_result(KIND_FIELD_END, 8'd0, ERR_NONE, state.col_counter,
                                    lc_eff);
               if (state.col_counter < FIELD_CAP) begin
                  state_next.col_counter = state.col_counter + 8'd1;
               end
            end else begin
               have_b = 1'b1;
               res_b  = make_result(KIND_DATA, in_byte, ERR_NONE, state.col_counter,
                                    lc_eff);
            end
         end
      end

      // Pack the results in order and flag the final one.
      if (have_a && have_b) begin
         res0      = res_a;
         res1      = res_b;
         res1.last = 1'b1;
         res_count = 2'd2;
      end else if (have_a) begin
         res0      = res_a;
         res0.last = 1'b1;
         res_count = 2'd1;
      end else if (have_b) begin
         res0      = res_b;
         res0.last = 1'b1;
         res_count = 2'd1;
      end
   end

endmodule

// ----- rtl/core/erd_rsp_fifo.sv -----
// Four-entry result queue that takes up to two results per cycle.
module erd_rsp_fifo import erd_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic [1:0]     push_count,
   input  erd_result_type push0,
   input  erd_result_type push1,
   input  logic           pop,
   output erd_result_type head,
   output logic           not_empty,
   output logic           has_room
);

   erd_result_type entry_ff [RSP_DEPTH];
   logic [1:0] wr_ptr_ff;
   logic [1:0] wr_ptr_in;
   logic [1:0] rd_ptr_ff;
   logic [1:0] rd_ptr_in;
   logic [2:0] count_ff;
   logic [2:0] count_in;
   logic       pop_ok;

   assign pop_ok    = pop && (count_ff != 3'd0);
   assign not_empty = (count_ff != 3'd0);
   assign has_room  = (count_ff <= RSP_ROOM_LIMIT);
   assign head      = entry_ff[rd_ptr_ff];

   // Pointer and fill level updates.
   always_comb begin
      wr_ptr_in = wr_ptr_ff + push_count;
      rd_ptr_in = rd_ptr_ff + {1'b0, pop_ok};
      count_in  = count_ff + {1'b0, push_count} - {2'b00, pop_ok};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 2'd0;
         rd_ptr_ff <= 2'd0;
         count_ff  <= 3'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Result storage; the second result goes one slot after the first.
   always_ff @(posedge clock) begin
      if (push_count != 2'd0) begin
         entry_ff[wr_ptr_ff] <= push0;
      end
      if (push_count == 2'd2) begin
         entry_ff[wr_ptr_ff + 2'd1] <= push1;
      end
   end

   // The queue never holds more than its depth.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= 3'(RSP_DEPTH))
      else $error("result queue overfilled");

   // Pushes only happen when two entries are free.
   a_push_room: assert property (@(posedge clock) disable iff (reset)
      (push_count != 2'd0) |-> has_room)
      else $error("push into a queue without room");

   // A pop with nothing pushed lowers the fill level by one.
   a_pop_level: assert property (@(posedge clock) disable iff (reset)
      (pop_ok && (push_count == 2'd0)) |=> (count_ff == $past(count_ff) - 3'd1))
      else $error("fill level wrong after pop");

endmodule
